/* rtl/scc_pkg.sv */
package scc_pkg;

  // Table geometry and height width.
  localparam int unsigned MAX_ENTRIES = 1024;
  localparam int unsigned HEIGHT_BITS = 16;

  // Widths of the channel fields.
  localparam int unsigned HEIGHT_FIELD_W = 16;
  localparam int unsigned COUNT_FIELD_W  = 11;

  // Effective height width: bits above HEIGHT_BITS and above the field are dropped.
  localparam int unsigned H_W = (HEIGHT_BITS < HEIGHT_FIELD_W) ? HEIGHT_BITS : HEIGHT_FIELD_W;
  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_ENTRIES);

  // Ordering kept by a table.
  typedef enum logic {
    ORDER_ASC,   // strictly ascending, find first entry >= height
    ORDER_DESC   // non-increasing, find first entry < height
  } scc_order_e;

  typedef struct packed {
    logic           start;   // begin a search for height
    logic           commit;  // write the height and update the count
    logic           clear;   // with commit: empty the table afterwards
    logic [H_W-1:0] height;
  } scc_ctrl_t;

  typedef struct packed {
    logic             done;        // search has converged
    logic             ovf;         // commit would overflow the table
    logic [CNT_W-1:0] count_next;  // count after commit
  } scc_stat_t;

  function automatic logic [CNT_W-1:0] scc_mid(logic [CNT_W-1:0] lo, logic [CNT_W-1:0] hi);
    logic [CNT_W-1:0] span;
    span = hi - lo;
    return lo + (span >> 1);
  endfunction

  function automatic logic [COUNT_FIELD_W-1:0] scc_fit_count(logic [CNT_W-1:0] c);
    logic [31:0] wide;
    wide = 32'(c);
    return wide[COUNT_FIELD_W-1:0];
  endfunction

endpackage

/* rtl/scc_if.sv */
interface scc_in_if;
  import scc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [HEIGHT_FIELD_W-1:0] height;
  logic                      last;

  modport source (output valid, output height, output last, input ready);
  modport sink   (input valid, input height, input last, output ready);
endinterface

interface scc_out_if;
  import scc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [COUNT_FIELD_W-1:0] longest_run;
  logic [COUNT_FIELD_W-1:0] covers_needed;
  logic                     overflow;

  modport source (output valid, output longest_run, output covers_needed, output overflow,
                  input ready);
  modport sink   (input valid, input longest_run, input covers_needed, input overflow,
                  output ready);
endinterface

/* rtl/scc_table.sv */
module scc_table
  import scc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  scc_order_e order_i,
  input  scc_ctrl_t  ctrl_i,
  output scc_stat_t  stat_o
);

  logic [H_W-1:0]   mem [MAX_ENTRIES];
  logic [H_W-1:0]   rdata_q;
  logic [IDX_W-1:0] raddr;
  logic [CNT_W-1:0] lo_q, lo_d, hi_q, hi_d, count_q, count_d;
  logic [CNT_W-1:0] mid, next_mid;
  logic             done, go_left, below_count, full, we;

  assign done        = (lo_q >= hi_q);
  assign mid         = scc_mid(lo_q, hi_q);
  assign below_count = (lo_q < count_q);
  assign full        = (count_q == MAX_COUNT);

  always_comb begin
    unique case (order_i)
      ORDER_ASC:  go_left = (rdata_q >= ctrl_i.height);
      ORDER_DESC: go_left = (rdata_q < ctrl_i.height);
      default:    go_left = 1'b0;
    endcase
  end

  // One halving step per cycle; the next probe address is issued from the
  // updated bounds so that its data arrives for the following step.
  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (ctrl_i.start) begin
      lo_d = '0;
      hi_d = count_q;
    end else if (!done) begin
      if (go_left) begin
        hi_d = mid;
      end else begin
        lo_d = mid + CNT_W'(1);
      end
    end
  end

  assign next_mid = scc_mid(lo_d, hi_d);
  assign raddr    = next_mid[IDX_W-1:0];

  assign stat_o.done       = done;
  assign stat_o.ovf        = !below_count && full;
  assign stat_o.count_next = (below_count || full) ? count_q : count_q + CNT_W'(1);

  assign we = ctrl_i.commit && (below_count || !full);

  always_comb begin
    count_d = count_q;
    if (ctrl_i.commit) begin
      count_d = ctrl_i.clear ? '0 : stat_o.count_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q    <= '0;
      hi_q    <= '0;
      count_q <= '0;
    end else begin
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[lo_q[IDX_W-1:0]] <= ctrl_i.height;
    end
    rdata_q <= mem[raddr];
  end

endmodule

/* rtl/subsequence_cover_counter.sv */
// Counts, over a sequence of heights, the greedy non-increasing piles and the
// longest non-increasing subsequence, both by binary search in sorted tables.
// in_i carries one height per item with a last flag; out_o gives one result
// item per sequence, after the item that has last set: the longest run, the
// number of piles and an overflow flag for a table that ran out of entries.
// Both tables are searched side by side, each in its own memory with one write
// port and one registered read port, one halving step per cycle. An item is
// searched until both tables have converged and then committed; in_i.ready
// is high only while no item is in work, so one item is taken at a time.
// The result of a sequence is registered in the cycle after its last item commits.
// The result sits in an output register; the block goes on taking items of
// the next sequence while it waits, and holds back only when a further last
// item finds that register still full.
// Reset empties both tables and clears the overflow flag and the output; no
// clearing pass is needed. Each last item empties both tables and clears the flag too.
module subsequence_cover_counter
  import scc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  scc_in_if.sink    in_i,
  scc_out_if.source out_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMMIT
  } state_e;

  state_e                   state_q, state_d;
  logic [H_W-1:0]           h_q, h_d;
  logic                     last_q, last_d;
  logic                     ovf_seen_q, ovf_seen_d;
  logic                     out_valid_q, out_valid_d;
  logic [COUNT_FIELD_W-1:0] run_q, run_d, covers_q, covers_d;
  logic                     out_ovf_q, out_ovf_d;

  scc_ctrl_t ctrl;
  scc_stat_t pile_stat, tail_stat;
  logic      accept, can_commit, ovf_all;

  assign accept     = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  // A last item waits in commit until the output register is free.
  assign can_commit = !last_q || !out_valid_q || out_o.ready;
  assign ovf_all    = ovf_seen_q || pile_stat.ovf || tail_stat.ovf;

  assign ctrl.start  = accept;
  assign ctrl.commit = (state_q == ST_COMMIT) && can_commit;
  assign ctrl.clear  = last_q;
  assign ctrl.height = h_q;

  scc_table u_piles (
    .clk_i,
    .rst_ni,
    .order_i (ORDER_ASC),
    .ctrl_i  (ctrl),
    .stat_o  (pile_stat)
  );

  scc_table u_tails (
    .clk_i,
    .rst_ni,
    .order_i (ORDER_DESC),
    .ctrl_i  (ctrl),
    .stat_o  (tail_stat)
  );

  always_comb begin
    state_d     = state_q;
    h_d         = h_q;
    last_d      = last_q;
    ovf_seen_d  = ovf_seen_q;
    out_valid_d = out_valid_q && !out_o.ready;
    run_d       = run_q;
    covers_d    = covers_q;
    out_ovf_d   = out_ovf_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          h_d     = in_i.height[H_W-1:0];
          last_d  = in_i.last;
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (pile_stat.done && tail_stat.done) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (can_commit) begin
          state_d = ST_IDLE;
          if (last_q) begin
            out_valid_d = 1'b1;
            run_d       = scc_fit_count(tail_stat.count_next);
            covers_d    = scc_fit_count(pile_stat.count_next);
            out_ovf_d   = ovf_all;
            ovf_seen_d  = 1'b0;
          end else begin
            ovf_seen_d  = ovf_all;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      h_q         <= '0;
      last_q      <= 1'b0;
      ovf_seen_q  <= 1'b0;
      out_valid_q <= 1'b0;
      run_q       <= '0;
      covers_q    <= '0;
      out_ovf_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      h_q         <= h_d;
      last_q      <= last_d;
      ovf_seen_q  <= ovf_seen_d;
      out_valid_q <= out_valid_d;
      run_q       <= run_d;
      covers_q    <= covers_d;
      out_ovf_q   <= out_ovf_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.longest_run   = run_q;
  assign out_o.covers_needed = covers_q;
  assign out_o.overflow      = out_ovf_q;

endmodule

/* test/tb_subsequence_cover_counter.sv */
`timescale 1ns / 1ps

module tb_subsequence_cover_counter;
  import scc_pkg::*;

  typedef struct packed {
    logic [COUNT_FIELD_W-1:0] longest_run;
    logic [COUNT_FIELD_W-1:0] covers_needed;
    logic                     overflow;
  } run_summary_t;

  typedef enum {
    SHAPE_SCATTER,
    SHAPE_NARROW,
    SHAPE_RISING,
    SHAPE_FALLING,
    SHAPE_EXTREME
  } height_shape_e;

  localparam int unsigned     HOLD_CYCLES   = 400;
  localparam int unsigned     SETTLE_CYCLES = 40;
  localparam int unsigned     RANDOM_ITEMS  = 1350;
  localparam int unsigned     CALM_AFTER    = 950;
  localparam longint unsigned LIMIT_CYCLES  = 800000;

  logic clk_i = 1'b0;
  logic rst_ni;

  scc_in_if  in_if ();
  scc_out_if out_if ();

  subsequence_cover_counter DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predicted table contents for the sequence currently open.
  logic [H_W-1:0] pile_top [MAX_ENTRIES];
  logic [H_W-1:0] run_tail [MAX_ENTRIES];
  int unsigned    piles_open;
  int unsigned    run_len;
  bit             table_full_hit;

  run_summary_t summary_q [$];
  run_summary_t due_summary;
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;
  int unsigned  hold_until = 0;
  bit           idle_on;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Folds one height into both tables and, on the closing item, queues the
  // summary that the block must give and empties the tables.
  function automatic void fold_height(input logic [HEIGHT_FIELD_W-1:0] h_in, input logic closing);
    logic [H_W-1:0] h;
    int unsigned    lo;
    int unsigned    hi;
    int unsigned    mid;
    run_summary_t   s;
    h = h_in[H_W-1:0];

    lo = 0;
    hi = piles_open;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (pile_top[mid] >= h) hi = mid;
      else lo = mid + 1;
    end
    if (lo < piles_open) begin
      pile_top[lo] = h;
    end else if (piles_open < MAX_ENTRIES) begin
      pile_top[piles_open] = h;
      piles_open++;
    end else begin
      table_full_hit = 1'b1;
    end

    lo = 0;
    hi = run_len;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (run_tail[mid] < h) hi = mid;
      else lo = mid + 1;
    end
    if (lo < run_len) begin
      run_tail[lo] = h;
    end else if (run_len < MAX_ENTRIES) begin
      run_tail[run_len] = h;
      run_len++;
    end else begin
      table_full_hit = 1'b1;
    end

    if (closing) begin
      s.longest_run   = COUNT_FIELD_W'(run_len);
      s.covers_needed = COUNT_FIELD_W'(piles_open);
      s.overflow      = table_full_hit;
      summary_q       = {summary_q, s};
      piles_open     = 0;
      run_len        = 0;
      table_full_hit = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so that the next item follows without a gap.
  task automatic send_item(input logic [HEIGHT_FIELD_W-1:0] h, input logic closing);
    if (idle_on && $urandom_range(0, 99) < 16) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_if.height <= h;
    in_if.last   <= closing;
    in_if.valid  <= 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    fold_height(h, closing);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (summary_q.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_sequence(input height_shape_e shape, input int unsigned len);
    int          prev;
    int          step;
    int          pick;
    int unsigned i;
    prev = $urandom_range(0, 65535);
    for (i = 0; i < len; i++) begin
      step = $urandom_range(0, 400);
      case (shape)
        SHAPE_SCATTER: prev = $urandom_range(0, 65535);
        SHAPE_NARROW:  prev = $urandom_range(0, 7);
        SHAPE_RISING:  prev = (prev + step > 65535) ? 65535 : prev + step;
        SHAPE_FALLING: prev = (prev < step) ? 0 : prev - step;
        default: begin
          pick = $urandom_range(0, 4);
          prev = (pick == 0) ? 0 : (pick == 1) ? 1 : (pick == 2) ? 32768 :
                 (pick == 3) ? 65534 : 65535;
        end
      endcase
      send_item(HEIGHT_FIELD_W'(prev), i == len - 1);
    end
  endtask

  task automatic test_single_items();
    send_item(16'h0000, 1'b1);
    send_item(16'hFFFF, 1'b1);
    send_item(16'h5555, 1'b1);
    send_item(16'hAAAA, 1'b1);
  endtask

  task automatic test_plateaus();
    send_item(16'h1234, 1'b0);
    send_item(16'h1234, 1'b0);
    send_item(16'h1234, 1'b0);
    send_item(16'h1234, 1'b1);
  endtask

  task automatic test_slopes();
    send_item(16'h0000, 1'b0);
    send_item(16'h0001, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(16'hFFFF, 1'b1);
    send_item(16'hFFFF, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(16'h0001, 1'b0);
    send_item(16'h0000, 1'b1);
    // Mixed order, where piles and the run differ.
    send_item(16'd5, 1'b0);
    send_item(16'd3, 1'b0);
    send_item(16'd4, 1'b0);
    send_item(16'd4, 1'b0);
    send_item(16'd1, 1'b0);
    send_item(16'd2, 1'b1);
  endtask

  // A strictly rising sequence opens a pile per item until the table is full;
  // the small height at the end replaces a top and must not overflow again.
  task automatic test_pile_overflow();
    int i;
    for (i = 0; i <= int'(MAX_ENTRIES); i++) send_item(HEIGHT_FIELD_W'(i * 60), 1'b0);
    send_item(16'h0000, 1'b1);
    wait_drained();
  endtask

  // Equal heights extend the run until its table is full.
  task automatic test_run_overflow();
    int i;
    for (i = 0; i <= int'(MAX_ENTRIES); i++) send_item(16'd1000, 1'b0);
    send_item(16'hFFFF, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_sequences();
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 120) : $urandom_range(1, 30);
      send_sequence(height_shape_e'($urandom_range(0, 4)), len);
      sent += len;
      // Towards the end both sides run flat out.
      if (sent >= CALM_AFTER) idle_on = 1'b0;
    end
    idle_on = 1'b1;
    wait_drained();
  endtask

  // The receiver holds off while short sequences keep coming, so the output
  // register fills and the block must stall its input.
  task automatic test_output_backpressure();
    int i;
    hold_until = cycle_count + HOLD_CYCLES;
    for (i = 0; i < 40; i++) begin
      send_sequence(height_shape_e'($urandom_range(0, 4)), $urandom_range(1, 3));
    end
    wait_drained();
  endtask

  always @(negedge clk_i) begin
    if (cycle_count < hold_until) out_if.ready <= 1'b0;
    else if (idle_on && $urandom_range(0, 99) < 16) out_if.ready <= 1'b0;
    else out_if.ready <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (summary_q.size() == 0) begin
        report_mismatch("result item with no sequence closed");
      end else begin
        due_summary = summary_q.pop_front();
        if (out_if.longest_run !== due_summary.longest_run)
          report_mismatch($sformatf("longest_run %0d, expected %0d",
                                    out_if.longest_run, due_summary.longest_run));
        if (out_if.covers_needed !== due_summary.covers_needed)
          report_mismatch($sformatf("covers_needed %0d, expected %0d",
                                    out_if.covers_needed, due_summary.covers_needed));
        if (out_if.overflow !== due_summary.overflow)
          report_mismatch($sformatf("overflow %0b, expected %0b",
                                    out_if.overflow, due_summary.overflow));
      end
    end
  end

  initial begin
    #(LIMIT_CYCLES * 20);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    in_if.valid    = 1'b0;
    in_if.height   = '0;
    in_if.last     = 1'b0;
    out_if.ready   = 1'b0;
    rst_ni         = 1'b0;
    idle_on        = 1'b1;
    piles_open     = 0;
    run_len        = 0;
    table_full_hit = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_single_items();
    test_plateaus();
    test_slopes();
    wait_drained();
    test_pile_overflow();
    test_run_overflow();
    test_random_sequences();
    test_output_backpressure();

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/scc_pkg.sv
rtl/scc_if.sv
rtl/scc_table.sv
rtl/subsequence_cover_counter.sv
test/tb_subsequence_cover_counter.sv
